FILE: hdl/lcd_pkg.sv
package lcd_pkg;

  // default sizes
  localparam int DEF_MAX_WORKERS = 16;
  localparam int DEF_NUM_PHASES  = 16;
  localparam int DEF_INDEX_BITS  = 24;

  // fixed field widths
  localparam int OUT_W     = 32;
  localparam int ITEM_W    = 24;
  localparam int CHUNK_W   = 24;
  localparam int WORKERS_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // commands
  localparam logic [1:0] CMD_REQUEST    = 2'd0;
  localparam logic [1:0] CMD_CLR_WORKER = 2'd1;
  localparam logic [1:0] CMD_CLR_PHASE  = 2'd2;

  // schedule modes
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_DYNAMIC = 2'd1;
  localparam logic [1:0] MODE_GUIDED  = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK   = 2'd2;

  // config reset values
  localparam logic [1:0]           RST_MODE    = MODE_DYNAMIC;
  localparam logic [WORKERS_W-1:0] RST_WORKERS = 5'd1;
  localparam logic [CHUNK_W-1:0]   RST_CHUNK   = 24'd64;

  // shared unit operations
  localparam logic [1:0] ALU_LOAD  = 2'd0;
  localparam logic [1:0] ALU_SHADD = 2'd1;
  localparam logic [1:0] ALU_ADD   = 2'd2;
  localparam logic [1:0] ALU_DIV   = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        worker_id;
    logic [3:0]        phase;
    logic [ITEM_W-1:0] total_items;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] range_start;
    logic [OUT_W-1:0] range_end;
    logic             exhausted;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic [1:0]       op;
    logic             bit_in;
    logic [OUT_W-1:0] operand;
  } alu_ctl_t;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             sat;
  } alu_res_t;

endpackage

FILE: hdl/lcd_alu.sv
// Shared step unit: saturating shift-add multiply steps, plain add,
// restoring divide steps (dividend in acc[23:0], divisor in operand[4:0]).
module lcd_alu import lcd_pkg::*; (
  input  logic     clk,
  input  alu_ctl_t ctl,
  output alu_res_t res
);

  logic [OUT_W-1:0] acc_r, acc_nxt;
  logic             sat_r, sat_nxt;
  logic [4:0]       rem_r, rem_nxt;
  logic [OUT_W+1:0] add_a, add_b, sum;
  logic             add_ci;
  logic [5:0]       div_sh;
  logic             ge;

  always_comb begin
    div_sh = {rem_r, acc_r[ITEM_W-1]};
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (ctl.op)
      ALU_SHADD: begin
        add_a = {1'b0, acc_r, 1'b0};
        add_b = ctl.bit_in ? (OUT_W+2)'(ctl.operand) : '0;
      end
      ALU_ADD: begin
        add_a = (OUT_W+2)'(acc_r);
        add_b = (OUT_W+2)'(ctl.operand);
      end
      ALU_DIV: begin
        add_a  = (OUT_W+2)'(div_sh);
        add_b  = ~((OUT_W+2)'(ctl.operand[4:0]));
        add_ci = 1'b1;
      end
      default: begin
      end
    endcase
    sum = add_a + add_b + (OUT_W+2)'(add_ci);
    ge  = !sum[OUT_W+1];

    acc_nxt = acc_r;
    sat_nxt = sat_r;
    rem_nxt = rem_r;
    if (ctl.en) begin
      case (ctl.op)
        ALU_LOAD: begin
          acc_nxt = ctl.operand;
          sat_nxt = 1'b0;
          rem_nxt = '0;
        end
        ALU_SHADD, ALU_ADD: begin
          acc_nxt = sum[OUT_W-1:0];
          sat_nxt = sat_r | (sum[OUT_W+1:OUT_W] != 2'b00);
        end
        ALU_DIV: begin
          rem_nxt = ge ? sum[4:0] : div_sh[4:0];
          acc_nxt = {acc_r[OUT_W-2:0], ge};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sat_r <= sat_nxt;
    rem_r <= rem_nxt;
  end

  assign res.value = acc_r;
  assign res.sat   = sat_r;

endmodule

FILE: hdl/lcd_store.sv
// Small state table: one write and one registered read per cycle.
// Entries never written read as zero through per-entry valid bits.
module lcd_store import lcd_pkg::*; #(
  parameter int DEPTH = DEF_NUM_PHASES,
  parameter int WIDTH = DEF_INDEX_BITS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  localparam int ENTRIES = 1 << AW;

  logic [WIDTH-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [WIDTH-1:0]   rd_mem_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_mem_r : '0;

endmodule

FILE: hdl/loop_chunk_dispatcher.sv
// Loop chunk dispatcher. A word is taken when start is high and busy is low;
// busy then stays high until the answer is ready, and the answer appears on
// out_data for exactly one cycle with out_valid, in the first cycle busy is low.
// The receiver cannot stall it, so out_data must be captured on that strobe.
// A new word may be issued in the same cycle the previous answer shows.
// Busy time per word is set by one shared step unit (one adder) that is
// reused under the sequencer here:
//   clear commands, unused commands, out-of-range worker/phase and
//   exhausted dynamic/guided loops: table read only;
//   dynamic: table read, then the range bound;
//   guided: 24 restoring divide steps of remaining / workers;
//   static: 5 multiply steps by the worker count, one add of the
//   worker id, 24 multiply steps by the chunk size, the multiply skipped
//   when the chunk number alone already overflows 32 bits.
// The strobe cycle is also the first cycle a new word can be taken.
// Config writes (cfg_ready is always high) are meant to happen
// only while idle.
module loop_chunk_dispatcher import lcd_pkg::*; #(
  parameter int MAX_WORKERS = DEF_MAX_WORKERS,
  parameter int NUM_PHASES  = DEF_NUM_PHASES,
  parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  in_word_t             in_data,
  output logic                 busy,
  output logic                 out_valid,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int WAW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int PAW = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
  localparam logic [ITEM_W-1:0] N_MASK = (INDEX_BITS >= ITEM_W) ? '1 :
                                         ITEM_W'((33'd1 << INDEX_BITS) - 33'd1);
  localparam logic [OUT_W-1:0] OUT_SAT = '1;

  // step counter start values
  localparam logic [4:0] CNT_K = 5'(WORKERS_W - 1);
  localparam logic [4:0] CNT_C = 5'(CHUNK_W - 1);
  localparam logic [4:0] CNT_D = 5'(ITEM_W - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;  // table data ready, pick path
  localparam logic [2:0] S_KMUL = 3'd2;  // job count * workers
  localparam logic [2:0] S_WID  = 3'd3;  // + worker id
  localparam logic [2:0] S_CAP  = 3'd4;  // hold chunk number
  localparam logic [2:0] S_CMUL = 3'd5;  // chunk number * chunk size
  localparam logic [2:0] S_DIV  = 3'd6;  // remaining / workers
  localparam logic [2:0] S_FIN  = 3'd7;  // bound the range, update offset

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           mode_r;
  logic [WORKERS_W-1:0] workers_r;
  logic [CHUNK_W-1:0]   chunk_r;

  logic [1:0]           cmd_r;
  logic [3:0]           wid_r, ph_r;
  logic [ITEM_W-1:0]    n_r;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [OUT_W-1:0]     a_r;
  logic                 a_sat_r;
  logic                 cap_en;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_r, out_nxt;

  logic                 accept;
  logic [WORKERS_W-1:0] k;
  logic [CHUNK_W-1:0]   c;
  logic                 wid_ok, ph_ok;

  logic [INDEX_BITS-1:0] jobs_rd, off_rd;
  logic                  job_we, phs_we;
  logic [INDEX_BITS-1:0] job_wdata, phs_wdata;

  alu_ctl_t             alu_ctl;
  alu_res_t             alu_res;

  logic [OUT_W-1:0]     n32, off32, st_start;
  logic [OUT_W:0]       st_sum, dyn_sum;
  logic [CHUNK_W-1:0]   len, quot;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // zero workers / zero chunk act as one
  assign k = (workers_r == '0) ? WORKERS_W'(1) : workers_r;
  assign c = (chunk_r == '0) ? CHUNK_W'(1) : chunk_r;

  assign wid_ok = (9'(wid_r) < 9'(MAX_WORKERS));
  assign ph_ok  = (9'(ph_r) < 9'(NUM_PHASES));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RST_MODE;
      workers_r <= RST_WORKERS;
      chunk_r   <= RST_CHUNK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:    mode_r    <= cfg_data[1:0];
        REG_WORKERS: workers_r <= cfg_data[WORKERS_W-1:0];
        REG_CHUNK:   chunk_r   <= cfg_data[CHUNK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per-worker job counts and per-phase shared offsets
  lcd_store #(
    .DEPTH (MAX_WORKERS),
    .WIDTH (INDEX_BITS),
    .AW    (WAW)
  ) u_jobs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (WAW'(in_data.worker_id)),
    .rd_data (jobs_rd),
    .wr_en   (job_we),
    .wr_addr (WAW'(wid_r)),
    .wr_data (job_wdata)
  );

  lcd_store #(
    .DEPTH (NUM_PHASES),
    .WIDTH (INDEX_BITS),
    .AW    (PAW)
  ) u_offs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (PAW'(in_data.phase)),
    .rd_data (off_rd),
    .wr_en   (phs_we),
    .wr_addr (PAW'(ph_r)),
    .wr_data (phs_wdata)
  );

  lcd_alu u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .res (alu_res)
  );

  // range bounding
  assign n32   = OUT_W'(n_r);
  assign off32 = OUT_W'(off_rd);
  assign quot  = alu_res.value[CHUNK_W-1:0];

  // static start: saturated chunk number times chunk size
  assign st_start = (a_sat_r || alu_res.sat) ? OUT_SAT : alu_res.value;
  assign st_sum   = (OUT_W+1)'(st_start) + (OUT_W+1)'(c);

  // guided takes the larger of the share and the chunk
  assign len     = (mode_r == MODE_GUIDED && quot > c) ? quot : c;
  assign dyn_sum = (OUT_W+1)'(off32) + (OUT_W+1)'(len);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cap_en        = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    job_we        = 1'b0;
    job_wdata     = '0;
    phs_we        = 1'b0;
    phs_wdata     = '0;
    alu_ctl       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        out_nxt   = '0;
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_CLR_WORKER: begin
            job_we        = wid_ok;
            out_valid_nxt = 1'b1;
          end
          CMD_CLR_PHASE: begin
            phs_we        = ph_ok;
            out_valid_nxt = 1'b1;
          end
          CMD_REQUEST: begin
            if (mode_r == MODE_STATIC) begin
              if (!wid_ok) begin
                out_valid_nxt = 1'b1;
              end else begin
                // job count advances even when the range comes out empty
                job_we      = (jobs_rd < IDX_MAX);
                job_wdata   = jobs_rd + INDEX_BITS'(1);
                alu_ctl.en  = 1'b1;
                alu_ctl.op  = ALU_LOAD;
                cnt_nxt     = CNT_K;
                state_nxt   = S_KMUL;
              end
            end else if (!ph_ok) begin
              out_valid_nxt = 1'b1;
            end else if (off32 >= n32) begin
              out_nxt.range_start = off32;
              out_nxt.range_end   = off32;
              out_nxt.exhausted   = 1'b1;
              out_valid_nxt       = 1'b1;
            end else if (mode_r == MODE_GUIDED) begin
              alu_ctl.en      = 1'b1;
              alu_ctl.op      = ALU_LOAD;
              alu_ctl.operand = n32 - off32;
              cnt_nxt         = CNT_D;
              state_nxt       = S_DIV;
            end else begin
              state_nxt = S_FIN;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end

      S_KMUL: begin
        alu_ctl.en      = 1'b1;
        alu_ctl.op      = ALU_SHADD;
        alu_ctl.bit_in  = k[cnt_r[2:0]];
        alu_ctl.operand = OUT_W'(jobs_rd);
        cnt_nxt         = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = S_WID;
        end
      end

      S_WID: begin
        alu_ctl.en      = 1'b1;
        alu_ctl.op      = ALU_ADD;
        alu_ctl.operand = OUT_W'(wid_r);
        state_nxt       = S_CAP;
      end

      S_CAP: begin
        cap_en     = 1'b1;
        alu_ctl.en = 1'b1;
        alu_ctl.op = ALU_LOAD;
        cnt_nxt    = CNT_C;
        // chunk number past 32 bits: start saturates, skip the multiply
        state_nxt  = alu_res.sat ? S_FIN : S_CMUL;
      end

      S_CMUL: begin
        alu_ctl.en      = 1'b1;
        alu_ctl.op      = ALU_SHADD;
        alu_ctl.bit_in  = c[cnt_r];
        alu_ctl.operand = a_r;
        cnt_nxt         = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end

      S_DIV: begin
        alu_ctl.en      = 1'b1;
        alu_ctl.op      = ALU_DIV;
        alu_ctl.operand = OUT_W'(k);
        cnt_nxt         = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (mode_r == MODE_STATIC) begin
          out_nxt.range_start = st_start;
          if (st_start >= n32) begin
            out_nxt.range_end = st_start;
            out_nxt.exhausted = 1'b1;
          end else if (st_sum > (OUT_W+1)'(n32)) begin
            out_nxt.range_end = n32;
            out_nxt.exhausted = 1'b0;
          end else begin
            out_nxt.range_end = st_sum[OUT_W-1:0];
            out_nxt.exhausted = 1'b0;
          end
        end else begin
          out_nxt.range_start = off32;
          out_nxt.exhausted   = 1'b0;
          phs_we              = 1'b1;
          if (dyn_sum > (OUT_W+1)'(n32)) begin
            out_nxt.range_end = n32;
            phs_wdata         = INDEX_BITS'(n_r);
          end else begin
            out_nxt.range_end = dyn_sum[OUT_W-1:0];
            phs_wdata         = INDEX_BITS'(dyn_sum);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      wid_r <= in_data.worker_id;
      ph_r  <= in_data.phase;
      n_r   <= in_data.total_items & N_MASK;
    end
    if (cap_en) begin
      a_r     <= alu_res.value;
      a_sat_r <= alu_res.sat;
    end else if (accept) begin
      a_sat_r <= 1'b0;
    end
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

endmodule

FILE: hdl/lcd_checker.sv
module lcd_checker import lcd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_data
);

  // a taken word always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a word was taken");

  // the answer shows only once the block has gone idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // one answer per word, never two strobes in a row
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.exhausted) |->
      (out_data.range_start == out_data.range_end))
    else $error("exhausted range is not empty");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.range_end >= out_data.range_start))
    else $error("range end before range start");

endmodule

bind loop_chunk_dispatcher lcd_checker u_lcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: dv/loop_chunk_dispatcher_test.sv
`timescale 1ns / 100ps

module loop_chunk_dispatcher_test;
  import lcd_pkg::*;

  localparam int WORKERS  = DEF_MAX_WORKERS;
  localparam int PHASES   = DEF_NUM_PHASES;

  // loop index space and output saturation point
  localparam logic [63:0] INDEX_MAX = (64'd1 << DEF_INDEX_BITS) - 64'd1;
  localparam logic [63:0] OUT_SAT   = 64'hFFFF_FFFF;

  localparam logic [CHUNK_W-1:0] CHUNK_TOP = '1;
  localparam logic [ITEM_W-1:0]  ITEMS_TOP = '1;

  // codes the block does not define
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  in_word_t             in_data = '0;
  logic                 busy;
  logic                 out_valid;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // shadow copy of the block: config registers and the two tables
  logic [1:0]                mode_cfg = RST_MODE;
  logic [WORKERS_W-1:0]      workers_cfg = RST_WORKERS;
  logic [CHUNK_W-1:0]        chunk_cfg = RST_CHUNK;
  logic [DEF_INDEX_BITS-1:0] job_count [WORKERS];
  logic [DEF_INDEX_BITS-1:0] phase_ofs [PHASES];

  in_word_t  word_q[$];   // words waiting to be issued
  out_word_t grant_q[$];  // predicted answers, oldest first

  int idle_pct = 34;
  int mismatches = 0;
  int cfg_writes = 0;

  loop_chunk_dispatcher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hang guard: fails the run if it has not finished by then.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Works out the answer to one accepted word and updates the shadow tables.
  function automatic out_word_t grant_range(input in_word_t w);
    out_word_t   r;
    logic [63:0] k, c, n, jobs, first, len, share, stop;
    r = '0;
    k = 64'(workers_cfg);
    c = 64'(chunk_cfg);
    if (k == 0) k = 64'd1;   // zero workers or zero chunk act as one
    if (c == 0) c = 64'd1;
    n = 64'(w.total_items);
    case (w.command)
      CMD_CLR_WORKER: job_count[w.worker_id] = '0;
      CMD_CLR_PHASE:  phase_ofs[w.phase] = '0;
      CMD_REQUEST: begin
        if (mode_cfg == MODE_STATIC) begin
          // chunk number job*workers + id, start saturates at 32 bits
          jobs  = 64'(job_count[w.worker_id]);
          first = jobs * k * c + 64'(w.worker_id) * c;
          if (first > OUT_SAT) first = OUT_SAT;
          if (jobs < INDEX_MAX)
            job_count[w.worker_id] = job_count[w.worker_id] + DEF_INDEX_BITS'(1);
          stop = first + c;
          r.range_start = first[OUT_W-1:0];
          if (first >= n) begin
            r.range_end = first[OUT_W-1:0];
            r.exhausted = 1'b1;
          end else if (stop > n) begin
            r.range_end = n[OUT_W-1:0];
          end else begin
            r.range_end = stop[OUT_W-1:0];
          end
        end else begin
          // dynamic, guided and the unused mode share the phase offset
          first = 64'(phase_ofs[w.phase]);
          r.range_start = first[OUT_W-1:0];
          if (first >= n) begin
            r.range_end = first[OUT_W-1:0];
            r.exhausted = 1'b1;
          end else begin
            len = c;
            if (mode_cfg == MODE_GUIDED) begin
              share = (n - first) / k;
              if (share > len) len = share;
            end
            stop = first + len;
            if (stop > n) stop = n;
            r.range_end = stop[OUT_W-1:0];
            phase_ofs[w.phase] = stop[DEF_INDEX_BITS-1:0];
          end
        end
      end
      default: ;   // unused command: all zero, tables untouched
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
  endtask

  // Driver: a word stays on in_data with start high until busy is low at an
  // edge; the next word goes out right behind it unless this cycle idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start   <= 1'b1;
        in_data <= word_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: answers are checked before the word taken at the same edge is
  // predicted, since a new word may go in while the old answer shows.
  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          mismatches++;
          $display("%0t ns: answer with none expected, expected none, got %0h",
                   $time, out_data);
        end else begin
          want = grant_q.pop_front();
          if (out_data.range_start !== want.range_start)
            report_field("range_start", want.range_start, out_data.range_start);
          if (out_data.range_end !== want.range_end)
            report_field("range_end", want.range_end, out_data.range_end);
          if (out_data.exhausted !== want.exhausted)
            report_field("exhausted", OUT_W'(want.exhausted), OUT_W'(out_data.exhausted));
        end
      end
      if (start && !busy)
        grant_q.push_back(grant_range(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:    mode_cfg = cfg_data[1:0];
          REG_WORKERS: workers_cfg = cfg_data[WORKERS_W-1:0];
          REG_CHUNK:   chunk_cfg = cfg_data[CHUNK_W-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
    end
  end

  task automatic push_word(input logic [1:0] cmd, input logic [3:0] wid,
                           input logic [3:0] ph, input logic [ITEM_W-1:0] n);
    in_word_t w;
    w.command     = cmd;
    w.worker_id   = wid;
    w.phase       = ph;
    w.total_items = n;
    word_q.push_back(w);
  endtask

  // Returns at a rising edge once every queued word is answered.
  task automatic drain;
    @(negedge clk);
    while (word_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Leaves cfg_valid high; set_config drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    int seen;
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    wait (cfg_writes != seen);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [WORKERS_W-1:0] workers,
                            input logic [CHUNK_W-1:0] chunk);
    write_reg(REG_MODE, CFG_DAT_W'(mode));
    write_reg(REG_WORKERS, CFG_DAT_W'(workers));
    write_reg(REG_CHUNK, CFG_DAT_W'(chunk));
    cfg_valid <= 1'b0;
  endtask

  // Loop length: mostly a few chunks long so runs reach the end of the loop,
  // with zero, full scale and fully random lengths mixed in.
  function automatic logic [ITEM_W-1:0] pick_total();
    int unsigned roll, span;
    roll = $urandom_range(0, 99);
    span = (chunk_cfg == '0) ? 12 : 12 * 32'(chunk_cfg);
    if (span > 32'(ITEMS_TOP)) span = 32'(ITEMS_TOP);
    if (roll < 10) return '0;
    if (roll < 20) return ITEM_W'($urandom_range(0, 32'(ITEMS_TOP)));
    if (roll < 25) return ITEMS_TOP;
    return ITEM_W'($urandom_range(1, span));
  endfunction

  // Mostly runs of requests on one worker/phase, usually after a clear;
  // the rest stray words of any command.
  task automatic gen_traffic(input int count);
    int                made;
    int                len;
    logic [3:0]        wid;
    logic [3:0]        ph;
    logic [ITEM_W-1:0] n;
    made = 0;
    while (made < count) begin
      wid = 4'($urandom_range(0, 15));
      ph  = 4'($urandom_range(0, 15));
      n   = pick_total();
      if ($urandom_range(0, 99) < 20) begin
        push_word(2'($urandom_range(0, 3)), wid, ph, n);
        made++;
      end else begin
        if ($urandom_range(0, 99) < 70) begin
          push_word(mode_cfg == MODE_STATIC ? CMD_CLR_WORKER : CMD_CLR_PHASE,
                    wid, ph, pick_total());
          made++;
        end
        len = $urandom_range(1, 20);
        if (len > count - made) len = count - made;
        repeat (len) begin
          if ($urandom_range(0, 99) < 8) n = pick_total();  // loop length changes mid run
          push_word(CMD_REQUEST, wid, ph, n);
          made++;
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < WORKERS; i++) job_count[i] = '0;
    for (int i = 0; i < PHASES; i++) phase_ofs[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (dynamic, one worker, chunk 64): empty loop, a full
    // chunk, a clipped chunk, then a used-up loop.
    push_word(CMD_REQUEST, 4'd0, 4'd0, '0);
    push_word(CMD_REQUEST, 4'd0, 4'd0, 24'd100);
    push_word(CMD_REQUEST, 4'd0, 4'd0, 24'd100);
    push_word(CMD_REQUEST, 4'd0, 4'd0, 24'd100);
    push_word(CMD_UNUSED, 4'd15, 4'd15, ITEMS_TOP);
    push_word(CMD_CLR_PHASE, 4'd15, 4'd0, ITEMS_TOP);
    push_word(CMD_REQUEST, 4'd15, 4'd15, ITEMS_TOP);
    push_word(CMD_CLR_WORKER, 4'd15, 4'd15, '0);
    drain();

    // Static at the top of both ranges: every start but that of chunk zero lies past the loop.
    set_config(MODE_STATIC, 5'd16, CHUNK_TOP);
    push_word(CMD_REQUEST, 4'd15, 4'd0, ITEMS_TOP);
    push_word(CMD_REQUEST, 4'd0, 4'd0, ITEMS_TOP);
    push_word(CMD_REQUEST, 4'd0, 4'd0, ITEMS_TOP);
    push_word(CMD_CLR_WORKER, 4'd0, 4'd9, ITEMS_TOP);
    push_word(CMD_REQUEST, 4'd0, 4'd0, 24'd10);
    push_word(CMD_REQUEST, 4'd0, 4'd0, '0);
    drain();

    // Zero workers and zero chunk act as one: guided takes the whole loop.
    set_config(MODE_GUIDED, '0, '0);
    push_word(CMD_REQUEST, 4'd2, 4'd3, ITEMS_TOP);
    push_word(CMD_REQUEST, 4'd2, 4'd3, ITEMS_TOP);
    push_word(CMD_CLR_PHASE, 4'd2, 4'd3, '0);
    drain();

    // Guided chunks shrink with the remainder ...
    set_config(MODE_GUIDED, 5'd16, 24'd1);
    push_word(CMD_REQUEST, 4'd4, 4'd5, 24'd1600);
    push_word(CMD_REQUEST, 4'd4, 4'd5, 24'd1600);
    drain();

    // ... and the unused mode carries on the same offset as dynamic.
    set_config(MODE_UNUSED, 5'd4, 24'd1000);
    push_word(CMD_REQUEST, 4'd4, 4'd5, 24'd1600);
    push_word(CMD_REQUEST, 4'd4, 4'd5, 24'd1600);
    push_word(CMD_REQUEST, 4'd4, 4'd5, 24'd1600);
    push_word(CMD_UNUSED, 4'd0, 4'd0, '0);
    drain();

    // Random phases. Long static runs here push starts past 32 bits.
    set_config(MODE_STATIC, 5'd16, CHUNK_TOP);
    gen_traffic(70);
    drain();
    set_config(MODE_DYNAMIC, WORKERS_W'($urandom_range(1, 16)),
               CHUNK_W'($urandom_range(1, 300)));
    gen_traffic(65);
    drain();

    // back to back words, no idle cycles
    idle_pct = 0;
    set_config(MODE_GUIDED, WORKERS_W'($urandom_range(1, 16)),
               CHUNK_W'($urandom_range(1, 300)));
    gen_traffic(65);
    drain();
    idle_pct = 34;

    // sender holds off mid phase until every answer is back
    set_config(MODE_STATIC, WORKERS_W'($urandom_range(1, 16)),
               CHUNK_W'($urandom_range(1, 300)));
    gen_traffic(35);
    drain();
    gen_traffic(35);
    drain();

    set_config(MODE_GUIDED, 5'd1, 24'd1);
    gen_traffic(60);
    drain();
    set_config(MODE_UNUSED, WORKERS_W'($urandom_range(1, 16)),
               CHUNK_W'($urandom_range(1, 300)));
    gen_traffic(60);
    drain();
    set_config(MODE_GUIDED, 5'd16, CHUNK_W'($urandom_range(1, 300)));
    gen_traffic(60);
    drain();
    set_config(2'($urandom_range(0, 3)), WORKERS_W'($urandom_range(0, 16)),
               CHUNK_W'($urandom_range(0, 32'(CHUNK_TOP))));
    gen_traffic(75);
    drain();

    // let any stray answer show up before the verdict
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lcd_pkg.sv
hdl/lcd_alu.sv
hdl/lcd_store.sv
hdl/loop_chunk_dispatcher.sv
hdl/lcd_checker.sv
dv/loop_chunk_dispatcher_test.sv
